### rtl/pud_pkg.sv
// Package for the percent-unescape decoder: payload structs, byte classes,
// scan status codes, back-end state enum and the byte classifier. No dependencies.
`default_nettype none

package pud_pkg;

  localparam logic [7:0] CHAR_PCT = 8'h25;   // '%'
  localparam logic [7:0] CHAR_U   = 8'h75;   // 'u'

  // work buffer holds up to five pending bytes plus one new byte
  localparam int WORK_DEPTH = 6;
  localparam int CNT_W      = $clog2(WORK_DEPTH + 1);
  localparam int Q_DEPTH    = 2;
  localparam int QPTR_W     = $clog2(Q_DEPTH);
  localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [CNT_W-1:0] LEN_SHORT = CNT_W'(3);
  localparam logic [CNT_W-1:0] LEN_LONG  = CNT_W'(6);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] byte_v;
    logic       is_pct;
    logic       is_u;
    logic       is_hex;
    logic [3:0] hex_val;
  } cls_t;

  typedef struct packed {
    cls_t cls;
    logic last;
  } q_entry_t;

  typedef enum logic [1:0] {
    SCAN_DONE,
    SCAN_BAD,
    SCAN_WAIT
  } scan_t;

  typedef enum logic {
    ST_LOAD,
    ST_SCAN
  } back_state_t;

  typedef struct packed {
    logic             scanning;
    logic [CNT_W-1:0] count;
    logic             head_pct;
  } back_status_t;

  function automatic cls_t classify(input logic [7:0] b);
    cls_t c;
    c.byte_v  = b;
    c.is_pct  = (b == CHAR_PCT);
    c.is_u    = (b == CHAR_U);
    c.is_hex  = 1'b0;
    c.hex_val = 4'd0;
    if (b inside {[8'h30:8'h39]}) begin
      c.is_hex  = 1'b1;
      c.hex_val = 4'(b - 8'h30);
    end else if (b inside {[8'h61:8'h66]}) begin
      c.is_hex  = 1'b1;
      c.hex_val = 4'(b - 8'h57);
    end else if (b inside {[8'h41:8'h46]}) begin
      c.is_hex  = 1'b1;
      c.hex_val = 4'(b - 8'h37);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/pud_front.sv
// Front end: accepts input beats, classifies each byte and queues it.
// Depends on pud_pkg (classify, q_entry_t, queue sizes).
`default_nettype none

module pud_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pud_pkg::in_item_t in_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output pud_pkg::q_entry_t      pop_data,
  output logic [pud_pkg::QCNT_W-1:0] q_count
);
  import pud_pkg::*;

  q_entry_t            q_r [Q_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                push, pop;

  assign in_ready  = (cnt_r != QCNT_W'(Q_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = q_r[rd_ptr_r];
  assign q_count   = cnt_r;
  assign push      = in_valid && in_ready;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r].cls  <= classify(in_data.in_byte);
      q_r[wr_ptr_r].last <= in_data.in_last;
    end
  end

endmodule

`default_nettype wire

### rtl/pud_back.sv
// Back end (uses pud_pkg): appends queued bytes to the lookahead buffer, scans its
// head for escapes, emits one decoded byte per cycle into a free output register.
`default_nettype none

module pud_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               pop_valid,
  output logic                    pop_ready,
  input  wire pud_pkg::q_entry_t  pop_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pud_pkg::out_item_t      out_data,
  output pud_pkg::back_status_t   status
);
  import pud_pkg::*;

  back_state_t       state_r, state_nxt;
  cls_t              buf_r [WORK_DEPTH];
  cls_t              buf_nxt [WORK_DEPTH];
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  scan_t             scan;
  logic [7:0]        esc_val;
  logic [CNT_W-1:0]  esc_len;
  logic [CNT_W-1:0]  adv;
  logic              head_pct, hold_wait, emit_req, emit, slot_free, done_all;
  logic              decided;

  // escape scan over the buffer head
  always_comb begin
    scan    = SCAN_DONE;
    esc_val = 8'd0;
    esc_len = LEN_SHORT;
    decided = 1'b0;
    if (cnt_r < CNT_W'(2)) begin
      scan = SCAN_WAIT;
    end else if (buf_r[1].is_u) begin
      esc_len = LEN_LONG;
      esc_val = {buf_r[4].hex_val, buf_r[5].hex_val};
      for (int k = 2; k < 6; k++) begin
        if (!decided) begin
          if (CNT_W'(k) >= cnt_r) begin
            scan    = SCAN_WAIT;
            decided = 1'b1;
          end else if (!buf_r[k].is_hex) begin
            scan    = SCAN_BAD;
            decided = 1'b1;
          end
        end
      end
    end else begin
      esc_val = {buf_r[1].hex_val, buf_r[2].hex_val};
      for (int k = 1; k < 3; k++) begin
        if (!decided) begin
          if (CNT_W'(k) >= cnt_r) begin
            scan    = SCAN_WAIT;
            decided = 1'b1;
          end else if (!buf_r[k].is_hex) begin
            scan    = SCAN_BAD;
            decided = 1'b1;
          end
        end
      end
    end
  end

  assign head_pct  = (cnt_r != '0) && buf_r[0].is_pct;
  // an incomplete escape waits for more bytes unless the string ends here
  assign hold_wait = head_pct && (scan == SCAN_WAIT) && !last_r;
  assign adv       = (head_pct && scan == SCAN_DONE) ? esc_len : CNT_W'(1);
  assign slot_free = !out_valid_r || out_ready;
  assign emit_req  = (state_r == ST_SCAN) && (cnt_r != '0) && !hold_wait;
  assign emit      = emit_req && slot_free;
  assign done_all  = (cnt_r == '0) || hold_wait || (emit && cnt_r == adv);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (pop_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (done_all) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pop_ready     = (state_r == ST_LOAD);
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    for (int j = 0; j < WORK_DEPTH; j++) buf_nxt[j] = buf_r[j];

    if (state_r == ST_LOAD && pop_valid) begin
      // append at the first free slot
      for (int j = 0; j < WORK_DEPTH; j++) begin
        if (CNT_W'(j) == cnt_r) buf_nxt[j] = pop_data.cls;
      end
      cnt_nxt  = cnt_r + 1'b1;
      last_nxt = pop_data.last;
    end

    if (emit) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.out_byte = (head_pct && scan == SCAN_DONE) ? esc_val : buf_r[0].byte_v;
      out_data_nxt.out_last = last_r && (cnt_r == adv);
      cnt_nxt               = cnt_r - adv;
      // drop consumed bytes
      case (adv)
        CNT_W'(1): begin
          for (int j = 0; j < WORK_DEPTH - 1; j++) buf_nxt[j] = buf_r[j + 1];
        end
        LEN_SHORT: begin
          for (int j = 0; j < WORK_DEPTH - 3; j++) buf_nxt[j] = buf_r[j + 3];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < WORK_DEPTH; j++) buf_r[j] <= buf_nxt[j];
    out_data_r <= out_data_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign status.scanning = (state_r == ST_SCAN);
  assign status.count    = cnt_r;
  assign status.head_pct = head_pct;

endmodule

`default_nettype wire

### rtl/percent_unescape_decoder_core.sv
// Top level of the percent-unescape decoder: front classifier/queue and back scanner.
// Depends on pud_pkg, pud_front and pud_back.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------
//  in      | in  | in_valid/in_ready  | in_data   (in_byte, in_last)
//  out     | out | out_valid/out_ready| out_data  (out_byte, out_last)
//
// A byte that passes straight through is appended to the lookahead buffer in the
// load state and emitted in the scan state. A failed or flushed escape emits one
// byte per cycle from the buffer when output is free, up to six for one input byte.
// A two-entry queue separates input acceptance from the scanner. A result
// waiting in the output register holds the scanner until it is taken.
// Reset (rst_n low, synchronous) empties the queue and the lookahead buffer.
`default_nettype none

module percent_unescape_decoder_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pud_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pud_pkg::out_item_t      out_data
);
  import pud_pkg::*;

  logic                pop_valid, pop_ready;
  q_entry_t            pop_data;
  logic [QCNT_W-1:0]   q_count;
  back_status_t        bstat;

  pud_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .q_count   (q_count)
  );

  pud_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .status    (bstat)
  );

`ifndef SYNTH
  // queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QCNT_W'(Q_DEPTH))
    else $error("queue count above depth");

  // while loading, the lookahead holds at most five bytes
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !bstat.scanning |-> bstat.count <= CNT_W'(WORK_DEPTH - 1))
    else $error("pending count above five");

  // pending bytes always start with a percent sign
  a_pend_head: assert property (@(posedge clk) disable iff (!rst_n)
    (!bstat.scanning && bstat.count != '0) |-> bstat.head_pct)
    else $error("pending buffer head is not a percent sign");

  // hold a waiting result beat steady until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result beat changed while waiting");
`endif

endmodule

`default_nettype wire
